>>> src/h75_pkg.sv
package h75_pkg;

	localparam int DEF_PANEL_WIDTH   = 64;
	localparam int DEF_ROW_ADDR_BITS = 5;
	localparam int DEF_BIT_PLANES    = 8;

	localparam int BASE_W     = 10;
	localparam int ETIME_W    = 17;
	localparam int PIX_W      = 16;
	localparam int LANES_W    = 6;
	localparam int ROWOUT_W   = 5;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 32;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 2;

	localparam logic [BASE_W-1:0] ENABLE_TIME_BASE_RST = 10'd100;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_TICK    = 1'b1;
	localparam logic STEP_SHIFT = 1'b0;
	localparam logic STEP_LATCH = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COPY,
		ST_LOAD
	} h75_state_t;

	// Keep the top 5/6/5 bits of an 8-bit color triple.
	function automatic logic [PIX_W-1:0] rgb565(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	// Bit 'plane' of the squared-gamma RGB888 value, as {b, g, r}.
	function automatic logic [2:0] plane_bits(input logic [PIX_W-1:0] pix,
		input logic [2:0] plane);
		logic [9:0]  r_sq;
		logic [11:0] g_sq;
		logic [9:0]  b_sq;
		logic [7:0]  r8;
		logic [7:0]  g8;
		logic [7:0]  b8;
		r_sq = 10'(pix[15:11]) * 10'(pix[15:11]);
		g_sq = 12'(pix[10:5]) * 12'(pix[10:5]);
		b_sq = 10'(pix[4:0]) * 10'(pix[4:0]);
		r8   = r_sq[9:2];
		g8   = g_sq[11:4];
		b8   = b_sq[9:2];
		return {b8[plane], g8[plane], r8[plane]};
	endfunction

endpackage

>>> src/h75_apb.sv
module h75_apb (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [h75_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [h75_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [h75_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	output logic [h75_pkg::BASE_W-1:0]        enable_time_base
);

	logic [h75_pkg::BASE_W-1:0] base_q;

	// The single register sits at byte address zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= h75_pkg::ENABLE_TIME_BASE_RST;
		end else if (psel && penable && pwrite && (paddr == '0)) begin
			base_q <= pwdata[h75_pkg::BASE_W-1:0];
		end
	end

	assign prdata           = h75_pkg::APB_DATA_W'(base_q);
	assign pready           = 1'b1;
	assign enable_time_base = base_q;

endmodule

>>> src/h75_fb.sv
module h75_fb #(
	parameter int PANEL_WIDTH   = h75_pkg::DEF_PANEL_WIDTH,
	parameter int ROW_ADDR_BITS = h75_pkg::DEF_ROW_ADDR_BITS,
	localparam int HALF_DEPTH   = (1 << ROW_ADDR_BITS) * PANEL_WIDTH,
	localparam int AW           = $clog2(HALF_DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic                          wr_lower,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [h75_pkg::PIX_W-1:0]     wr_data,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [h75_pkg::PIX_W-1:0]     rd_upper,
	output logic [h75_pkg::PIX_W-1:0]     rd_lower,
	output logic                          clr_busy
);

	logic [h75_pkg::PIX_W-1:0] mem_up [HALF_DEPTH];
	logic [h75_pkg::PIX_W-1:0] mem_lo [HALF_DEPTH];
	logic [h75_pkg::PIX_W-1:0] rd_upper_q;
	logic [h75_pkg::PIX_W-1:0] rd_lower_q;
	logic [AW:0]               clr_q;

	assign clr_busy = (clr_q != (AW+1)'(HALF_DEPTH));

	// After reset both banks are swept to zero, one entry of each per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clr_busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy) begin
			mem_up[clr_q[AW-1:0]] <= '0;
			mem_lo[clr_q[AW-1:0]] <= '0;
		end else if (wr_en) begin
			if (wr_lower) begin
				mem_lo[wr_addr] <= wr_data;
			end else begin
				mem_up[wr_addr] <= wr_data;
			end
		end
		if (rd_en) begin
			rd_upper_q <= mem_up[rd_addr];
			rd_lower_q <= mem_lo[rd_addr];
		end
	end

	assign rd_upper = rd_upper_q;
	assign rd_lower = rd_lower_q;

endmodule

>>> src/h75_lbuf.sv
module h75_lbuf #(
	parameter int PANEL_WIDTH = h75_pkg::DEF_PANEL_WIDTH,
	localparam int CW         = $clog2(PANEL_WIDTH)
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [CW-1:0]                 wr_addr,
	input  logic [h75_pkg::PIX_W-1:0]     wr_upper,
	input  logic [h75_pkg::PIX_W-1:0]     wr_lower,
	input  logic                          rd_en,
	input  logic [CW-1:0]                 rd_addr,
	output logic [h75_pkg::PIX_W-1:0]     rd_upper,
	output logic [h75_pkg::PIX_W-1:0]     rd_lower
);

	logic [2*h75_pkg::PIX_W-1:0] mem [PANEL_WIDTH];
	logic [2*h75_pkg::PIX_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_lower, wr_upper};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_upper = rd_q[h75_pkg::PIX_W-1:0];
	assign rd_lower = rd_q[2*h75_pkg::PIX_W-1:h75_pkg::PIX_W];

endmodule

>>> src/hub75_matrix_scan_driver.sv
// A pixel write is stored at the edge of its transfer and gives no result. A tick passes
// through the load state, where it waits until the output register is free, into the
// output register; no new item is taken until the block is idle again. The first tick of
// a row pair first goes through the copy state, which copies both rows from the framebuffer
// into the line buffer. Reset: arst_n clears the state, the scan position, the output valid
// and the configuration register at once; the framebuffer is then swept to zero before items flow.
module hub75_matrix_scan_driver #(
	parameter int PANEL_WIDTH   = h75_pkg::DEF_PANEL_WIDTH,
	parameter int ROW_ADDR_BITS = h75_pkg::DEF_ROW_ADDR_BITS,
	parameter int BIT_PLANES    = h75_pkg::DEF_BIT_PLANES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// row_index[5:0], column_index[11:6], red[19:12], green[27:20], blue[35:28], zero fill
	input  logic [h75_pkg::S_TDATA_W-1:0]     s_tdata,
	// opcode
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// lane_bits[5:0], row_address[10:6], enable_time[27:11], zero fill
	output logic [h75_pkg::M_TDATA_W-1:0]     m_tdata,
	// step_kind
	output logic                              m_tuser,
	// plane_done
	output logic                              m_tlast,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [h75_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [h75_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [h75_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);

	localparam int HALF_DEPTH = (1 << ROW_ADDR_BITS) * PANEL_WIDTH;
	localparam int AW         = $clog2(HALF_DEPTH);
	localparam int CW         = $clog2(PANEL_WIDTH);
	localparam int CNW        = $clog2(PANEL_WIDTH + 2);
	localparam int PW         = (BIT_PLANES > 1) ? $clog2(BIT_PLANES) : 1;

	// Configuration register.
	logic [h75_pkg::BASE_W-1:0] base;

	h75_apb u_apb (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.enable_time_base (base)
	);

	// Control state and scan position.
	h75_pkg::h75_state_t        state_q, state_d;
	logic [ROW_ADDR_BITS-1:0]   scan_row_q;
	logic [PW-1:0]              plane_q;
	logic [CNW-1:0]             col_q;
	logic [CW:0]                copy_q;

	// Scan position of the tick being worked on, captured at its transfer.
	logic [ROW_ADDR_BITS-1:0]   row_s1;
	logic [PW-1:0]              plane_s1;
	logic [CNW-1:0]             col_s1;

	// Output register.
	logic                       m_valid_q;
	logic                       m_kind_q;
	logic [h75_pkg::LANES_W-1:0]  m_lanes_q;
	logic [h75_pkg::ROWOUT_W-1:0] m_row_q;
	logic [h75_pkg::ETIME_W-1:0]  m_etime_q;
	logic                       m_done_q;

	// Input field decode.
	logic [5:0] in_row;
	logic [5:0] in_col;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	logic [5:0] in_half;

	assign in_row   = s_tdata[5:0];
	assign in_col   = s_tdata[11:6];
	assign in_red   = s_tdata[19:12];
	assign in_green = s_tdata[27:20];
	assign in_blue  = s_tdata[35:28];
	// The row bits above the row address pick the upper or lower half of the panel.
	assign in_half  = in_row >> ROW_ADDR_BITS;

	logic transfer_in;
	logic tick_in;
	logic snap_needed;
	logic col_is_data;

	assign s_tready    = (state_q == h75_pkg::ST_IDLE);
	assign transfer_in = s_tvalid && s_tready;
	assign tick_in     = transfer_in && (s_tuser == h75_pkg::OP_TICK);
	// The line buffer is refilled on the first tick of each row pair, so writes made while a
	// pair is on the panel show up on its next pass.
	assign snap_needed = (plane_q == '0) && (col_q == '0);
	assign col_is_data = (32'(col_q) < PANEL_WIDTH);

	// Framebuffer ports. Writes out of the panel are dropped.
	logic                      fb_wr_en;
	logic [AW-1:0]             fb_wr_addr;
	logic                      fb_rd_en;
	logic [AW-1:0]             fb_rd_addr;
	logic [h75_pkg::PIX_W-1:0] fb_rd_upper;
	logic [h75_pkg::PIX_W-1:0] fb_rd_lower;
	logic                      clr_busy;

	assign fb_wr_en   = transfer_in && (s_tuser == h75_pkg::OP_WRITE) &&
		(in_half < 6'd2) && (32'(in_col) < PANEL_WIDTH);
	assign fb_wr_addr = AW'(in_row[ROW_ADDR_BITS-1:0]) * AW'(PANEL_WIDTH) + AW'(in_col);
	assign fb_rd_en   = (state_q == h75_pkg::ST_COPY) && (32'(copy_q) < PANEL_WIDTH);
	assign fb_rd_addr = AW'(row_s1) * AW'(PANEL_WIDTH) + AW'(copy_q);

	h75_fb #(
		.PANEL_WIDTH   (PANEL_WIDTH),
		.ROW_ADDR_BITS (ROW_ADDR_BITS)
	) u_fb (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fb_wr_en),
		.wr_lower (in_half[0]),
		.wr_addr  (fb_wr_addr),
		.wr_data  (h75_pkg::rgb565(in_red, in_green, in_blue)),
		.rd_en    (fb_rd_en),
		.rd_addr  (fb_rd_addr),
		.rd_upper (fb_rd_upper),
		.rd_lower (fb_rd_lower),
		.clr_busy (clr_busy)
	);

	// Line buffer ports. During the copy the framebuffer data of the previous cycle is written
	// one entry behind the read. A tick reads its column either at its transfer or, after a
	// copy, in the last copy cycle.
	logic                      lb_wr_en;
	logic [CW-1:0]             lb_wr_addr;
	logic                      lb_rd_en;
	logic [CW-1:0]             lb_rd_addr;
	logic [h75_pkg::PIX_W-1:0] lb_upper;
	logic [h75_pkg::PIX_W-1:0] lb_lower;
	logic                      copy_last;

	assign copy_last  = (state_q == h75_pkg::ST_COPY) && (copy_q == (CW+1)'(PANEL_WIDTH));
	assign lb_wr_en   = (state_q == h75_pkg::ST_COPY) && (copy_q != '0);
	assign lb_wr_addr = CW'(copy_q - 1'b1);
	assign lb_rd_en   = (tick_in && !snap_needed && col_is_data) || copy_last;
	assign lb_rd_addr = copy_last ? CW'(col_s1) : CW'(col_q);

	h75_lbuf #(
		.PANEL_WIDTH (PANEL_WIDTH)
	) u_lbuf (
		.clk      (clk),
		.wr_en    (lb_wr_en),
		.wr_addr  (lb_wr_addr),
		.wr_upper (fb_rd_upper),
		.wr_lower (fb_rd_lower),
		.rd_en    (lb_rd_en),
		.rd_addr  (lb_rd_addr),
		.rd_upper (lb_upper),
		.rd_lower (lb_lower)
	);

	// Next state. A tick waits in the load state until the output register is free.
	logic out_free;
	logic load_out;

	assign out_free = !m_valid_q || m_tready;
	assign load_out = (state_q == h75_pkg::ST_LOAD) && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			h75_pkg::ST_CLEAR: begin
				if (!clr_busy) begin
					state_d = h75_pkg::ST_IDLE;
				end
			end
			h75_pkg::ST_IDLE: begin
				if (tick_in) begin
					state_d = snap_needed ? h75_pkg::ST_COPY : h75_pkg::ST_LOAD;
				end
			end
			h75_pkg::ST_COPY: begin
				if (copy_last) begin
					state_d = h75_pkg::ST_LOAD;
				end
			end
			h75_pkg::ST_LOAD: begin
				if (out_free) begin
					state_d = h75_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = h75_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= h75_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Scan position advances at every tick transfer: columns, then the dummy and latch steps,
	// then planes, then row pairs, wrapping after the last pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q <= '0;
			plane_q    <= '0;
			col_q      <= '0;
		end else if (tick_in) begin
			if (col_q == CNW'(PANEL_WIDTH + 1)) begin
				col_q <= '0;
				if (plane_q == PW'(BIT_PLANES - 1)) begin
					plane_q    <= '0;
					scan_row_q <= scan_row_q + 1'b1;
				end else begin
					plane_q <= plane_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_q <= '0;
		end else if (tick_in) begin
			copy_q <= '0;
		end else if (state_q == h75_pkg::ST_COPY) begin
			copy_q <= copy_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_in) begin
			row_s1   <= scan_row_q;
			plane_s1 <= plane_q;
			col_s1   <= col_q;
		end
	end

	// Result of the tick: pixel bits for data columns, the row latch with its enable time on
	// the last step of a plane, and all zeros on the dummy step before it.
	logic                         res_kind;
	logic [h75_pkg::LANES_W-1:0]  res_lanes;
	logic [h75_pkg::ETIME_W-1:0]  res_etime;
	logic                         res_done;

	always_comb begin
		res_kind  = h75_pkg::STEP_SHIFT;
		res_lanes = '0;
		res_etime = '0;
		res_done  = 1'b0;
		priority if (32'(col_s1) < PANEL_WIDTH) begin
			res_lanes = {h75_pkg::plane_bits(lb_lower, 3'(plane_s1)),
				h75_pkg::plane_bits(lb_upper, 3'(plane_s1))};
		end else if (col_s1 == CNW'(PANEL_WIDTH + 1)) begin
			res_kind  = h75_pkg::STEP_LATCH;
			res_etime = h75_pkg::ETIME_W'(base) << plane_s1;
			res_done  = 1'b1;
		end else begin
			res_kind  = h75_pkg::STEP_SHIFT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_kind_q  <= res_kind;
			m_lanes_q <= res_lanes;
			m_row_q   <= h75_pkg::ROWOUT_W'(row_s1);
			m_etime_q <= res_etime;
			m_done_q  <= res_done;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_done_q;
	assign m_tdata  = h75_pkg::M_TDATA_W'({m_etime_q, m_row_q, m_lanes_q});

endmodule
